/* rtl/css_pkg.sv */
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants of the conveyor sort sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package css_pkg;

  localparam int TIMER_BITS     = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 4;
  localparam int NUM_SIZES      = 4;
  localparam int SIZE_BITS      = 3;
  localparam int PHASE_BITS     = 4;

  localparam int WINDOW_HALF  = 200;
  localparam int PULSE_TICKS  = 500;

  localparam logic [SIZE_BITS-1:0] SIZE_UNKNOWN = 3'd4;

  localparam logic [7:0] REGION_NORTH  = 8'h4E;
  localparam logic [7:0] REGION_CENTER = 8'h43;
  localparam logic [7:0] REGION_SOUTH  = 8'h53;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_BASE = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SETTLE_BASE = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_END         = 4'd8;

  localparam logic [NUM_SIZES-1:0][CFG_DATA_BITS-1:0] CENTER_RESET =
    {16'd2700, 16'd2150, 16'd1500, 16'd1200};
  localparam logic [NUM_SIZES-1:0][CFG_DATA_BITS-1:0] SETTLE_RESET =
    {16'd300, 16'd500, 16'd800, 16'd1100};

  typedef struct packed {
    logic       north_present;
    logic       center_present;
    logic       south_present;
    logic       byte_valid;
    logic [7:0] byte_value;
  } css_item_t;

  typedef struct packed {
    logic                  solenoid_north;
    logic                  solenoid_center;
    logic                  solenoid_south;
    logic                  motor_run;
    logic [SIZE_BITS-1:0]  size_class;
    logic [PHASE_BITS-1:0] phase;
    logic                  round_end;
  } css_result_t;

  typedef struct packed {
    logic [NUM_SIZES-1:0][CFG_DATA_BITS-1:0] center;
    logic [NUM_SIZES-1:0][CFG_DATA_BITS-1:0] settle;
  } css_cfg_t;

endpackage

`default_nettype wire

/* rtl/conveyor_sort_sequencer.sv */
// ----------------------------------------------------------------------------
// conveyor_sort_sequencer
// The result word for a tick is registered and valid in the cycle after the tick is taken.
// One tick word is taken per cycle while the result is not stalled by result_ready.
// Reset clears the sequencer to wait for a north arrival with size unknown
// and loads the default window centers and settle times.
// ----------------------------------------------------------------------------
`default_nettype none

module conveyor_sort_sequencer (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                item_valid,
  output logic                               item_ready,
  input  css_pkg::css_item_t                 item,
  output logic                               result_valid,
  input  wire                                result_ready,
  output css_pkg::css_result_t               result,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [css_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [css_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import css_pkg::*;

  css_cfg_t cfg;

  css_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  css_step u_step (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

/* rtl/css_regs.sv */
// ----------------------------------------------------------------------------
// css_regs
// Configuration register file holding the size window centers and settle
// times.
// ----------------------------------------------------------------------------
`default_nettype none

module css_regs (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [css_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire  [css_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output css_pkg::css_cfg_t                    cfg
);
  import css_pkg::*;

  logic [1:0] slot;

  assign cfg_ready = 1'b1;
  assign slot      = cfg_index[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center <= CENTER_RESET;
      cfg.settle <= SETTLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < CFG_SETTLE_BASE) begin
        cfg.center[slot] <= cfg_data;
      end else if (cfg_index < CFG_END) begin
        cfg.settle[slot] <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/css_step.sv */
// ----------------------------------------------------------------------------
// css_step
// Sequencer state and one-tick step logic with the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module css_step (
  input  wire                  clk,
  input  wire                  rst,
  input  css_pkg::css_cfg_t    cfg,
  input  wire                  item_valid,
  output logic                 item_ready,
  input  css_pkg::css_item_t   item,
  output logic                 result_valid,
  input  wire                  result_ready,
  output css_pkg::css_result_t result
);
  import css_pkg::*;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_WAIT_N      = 4'd0,
    PH_MEASURE     = 4'd1,
    PH_WAIT_REGION = 4'd2,
    PH_SETTLE_N    = 4'd3,
    PH_WAIT_C_ON   = 4'd4,
    PH_WAIT_C_OFF  = 4'd5,
    PH_SETTLE_C    = 4'd6,
    PH_WAIT_S_ON   = 4'd7,
    PH_WAIT_S_OFF  = 4'd8,
    PH_SETTLE_S    = 4'd9,
    PH_PULSE       = 4'd10,
    PH_WAIT_EXTRA  = 4'd11
  } phase_t;

  localparam logic [TIMER_BITS-1:0] TMAX       = '1;
  localparam logic [TIMER_BITS-1:0] ONE        = TIMER_BITS'(1);
  localparam logic [TIMER_BITS-1:0] PULSE_LAST = TIMER_BITS'(PULSE_TICKS - 1);

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] ms_counter, ms_counter_next;
  logic [TIMER_BITS-1:0] countdown, countdown_next;
  logic [TIMER_BITS-1:0] elapsed_wait, elapsed_wait_next;
  logic [SIZE_BITS-1:0]  size_reg, size_reg_next;
  logic [7:0]            region, region_next;
  logic                  region_held, region_held_next;
  logic                  extra_held, extra_held_next;
  logic                  round_end_next;

  logic                  accept;
  logic [SIZE_BITS-1:0]  size_class;
  logic [TIMER_BITS-1:0] settle_time;
  logic [31:0]           settle_ext;
  logic [31:0]           settle_diff;
  logic [31:0]           width_ext;
  logic [31:0]           lo_bound [NUM_SIZES];
  logic [31:0]           hi_bound [NUM_SIZES];
  logic [7:0]            station_code;
  phase_t                station_next;

  assign accept     = item_valid && item_ready;
  assign item_ready = !result_valid || result_ready;

  // Window classification of the measured width; the lowest class wins.
  always_comb begin
    width_ext  = 32'(ms_counter);
    size_class = SIZE_UNKNOWN;
    for (int i = NUM_SIZES - 1; i >= 0; i--) begin
      lo_bound[i] = (32'(cfg.center[i]) > 32'(WINDOW_HALF)) ?
                    32'(cfg.center[i]) - 32'(WINDOW_HALF) : 32'd0;
      hi_bound[i] = 32'(cfg.center[i]) + 32'(WINDOW_HALF);
      if (width_ext >= lo_bound[i] && width_ext <= hi_bound[i]) begin
        size_class = SIZE_BITS'(i);
      end
    end
  end

  // Settle delay less the region wait, clamped at zero and at the timer range.
  always_comb begin
    settle_ext  = 32'd0;
    settle_diff = 32'd0;
    settle_time = '0;
    if (size_reg < SIZE_UNKNOWN) begin
      settle_ext  = 32'(cfg.settle[size_reg[1:0]]);
      settle_diff = (settle_ext > 32'(elapsed_wait)) ?
                    settle_ext - 32'(elapsed_wait) : 32'd0;
      settle_time = (settle_diff > 32'(TMAX)) ? TMAX : TIMER_BITS'(settle_diff);
    end
  end

  always_comb begin
    region_next       = region;
    region_held_next  = region_held;
    extra_held_next   = extra_held;
    phase_next        = phase;
    ms_counter_next   = ms_counter;
    countdown_next    = countdown;
    elapsed_wait_next = elapsed_wait;
    size_reg_next     = size_reg;
    round_end_next    = 1'b0;
    station_code      = REGION_NORTH;
    station_next      = PH_WAIT_C_ON;

    if (item.byte_valid) begin
      if (!region_held) begin
        region_next      = item.byte_value;
        region_held_next = 1'b1;
      end else begin
        extra_held_next = 1'b1;
      end
    end

    unique case (phase)
      PH_SETTLE_N: begin
        station_code = REGION_NORTH;
        station_next = PH_WAIT_C_ON;
      end
      PH_SETTLE_C: begin
        station_code = REGION_CENTER;
        station_next = PH_WAIT_S_ON;
      end
      default: begin
        station_code = REGION_SOUTH;
        station_next = PH_WAIT_EXTRA;
      end
    endcase

    unique case (phase)
      PH_WAIT_N: begin
        if (item.north_present) begin
          ms_counter_next = ONE;
          phase_next      = PH_MEASURE;
        end
      end
      PH_MEASURE: begin
        if (item.north_present) begin
          ms_counter_next = (ms_counter != TMAX) ? ms_counter + ONE : TMAX;
        end else begin
          size_reg_next     = size_class;
          elapsed_wait_next = '0;
          phase_next        = PH_WAIT_REGION;
        end
      end
      PH_WAIT_REGION: begin
        if (region_held_next) begin
          countdown_next = settle_time;
          phase_next     = PH_SETTLE_N;
        end else begin
          elapsed_wait_next = (elapsed_wait != TMAX) ? elapsed_wait + ONE : TMAX;
        end
      end
      PH_SETTLE_N, PH_SETTLE_C, PH_SETTLE_S: begin
        if (countdown != '0) begin
          countdown_next = countdown - ONE;
        end else if (region_next == station_code) begin
          phase_next     = PH_PULSE;
          countdown_next = PULSE_LAST;
        end else begin
          phase_next = station_next;
        end
      end
      PH_WAIT_C_ON: begin
        if (item.center_present) begin
          phase_next = PH_WAIT_C_OFF;
        end
      end
      PH_WAIT_C_OFF: begin
        if (!item.center_present) begin
          countdown_next = settle_time;
          phase_next     = PH_SETTLE_C;
        end
      end
      PH_WAIT_S_ON: begin
        if (item.south_present) begin
          phase_next = PH_WAIT_S_OFF;
        end
      end
      PH_WAIT_S_OFF: begin
        if (!item.south_present) begin
          countdown_next = settle_time;
          phase_next     = PH_SETTLE_S;
        end
      end
      PH_PULSE: begin
        if (countdown != '0) begin
          countdown_next = countdown - ONE;
        end else begin
          phase_next     = PH_WAIT_N;
          round_end_next = 1'b1;
        end
      end
      PH_WAIT_EXTRA: begin
        if (extra_held_next) begin
          phase_next     = PH_WAIT_N;
          round_end_next = 1'b1;
        end
      end
      default: begin
        phase_next = PH_WAIT_N;
      end
    endcase

    if (phase_next == PH_WAIT_N && phase != PH_WAIT_N) begin
      region_held_next = 1'b0;
      extra_held_next  = 1'b0;
      size_reg_next    = SIZE_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT_N;
      ms_counter   <= '0;
      countdown    <= '0;
      elapsed_wait <= '0;
      size_reg     <= SIZE_UNKNOWN;
      region       <= '0;
      region_held  <= 1'b0;
      extra_held   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        ms_counter   <= ms_counter_next;
        countdown    <= countdown_next;
        elapsed_wait <= elapsed_wait_next;
        size_reg     <= size_reg_next;
        region       <= region_next;
        region_held  <= region_held_next;
        extra_held   <= extra_held_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (accept) begin
      result.solenoid_north  <= (phase_next == PH_PULSE) && (region_next == REGION_NORTH);
      result.solenoid_center <= (phase_next == PH_PULSE) && (region_next == REGION_CENTER);
      result.solenoid_south  <= (phase_next == PH_PULSE) && (region_next == REGION_SOUTH);
      result.motor_run       <= 1'b1;
      result.size_class      <= size_reg_next;
      result.phase           <= phase_next;
      result.round_end       <= round_end_next;
    end
  end

endmodule

`default_nettype wire
